>>> hdl/scc_pkg.sv
// Shared types, constants and BCD helpers for the serial calendar clock port.
// No dependencies; every other file of the block but scc_stream_if imports this package.
package scc_pkg;

    // Port function codes
    localparam logic [1:0] FUNC_CMD  = 2'd0;
    localparam logic [1:0] FUNC_PORT = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // Command codes run on a falling strobe
    localparam logic [2:0] CMD_HOLD  = 3'd0;
    localparam logic [2:0] CMD_SHIFT = 3'd1;
    localparam logic [2:0] CMD_SET   = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;

    // Bit positions in the written byte
    localparam int WV_DATA_BIT   = 3;
    localparam int WV_STROBE_BIT = 1;
    localparam int WV_CLOCK_BIT  = 2;

    // Width of the packed time word
    localparam int TIME_BITS = 40;

    localparam logic [4:0] READ_ONE  = 5'd16;
    localparam logic [4:0] READ_ZERO = 5'd0;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] write_value;
        logic [3:0] now_month;
        logic [2:0] now_weekday;
        logic [4:0] now_day;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [5:0] now_second;
    } t_in_item;

    typedef struct packed {
        logic [4:0] read_byte;
        logic       time_set;
        logic [3:0] set_month;
        logic [3:0] set_weekday;
        logic [7:0] set_day;
        logic [7:0] set_hour;
        logic [7:0] set_minute;
        logic [7:0] set_second;
    } t_out_item;

    // Binary to two BCD digits for values below 64; divide by ten through 205/2048
    function automatic logic [7:0] bin_to_bcd(input logic [5:0] v);
        logic [13:0] prod;
        logic [2:0]  q;
        logic [6:0]  q10;
        logic [3:0]  lo;
        prod = 14'(v) * 14'd205;
        q    = prod[13:11];
        q10  = 7'(q) * 7'd10;
        lo   = 4'(7'(v) - q10);
        return {1'b0, q, lo};
    endfunction

    // Two BCD digits to binary, digits above nine taken as they are
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        return 8'(8'(b[7:4]) * 8'd10) + 8'(b[3:0]);
    endfunction

endpackage

>>> hdl/scc_stream_if.sv
// Valid/ready stream channel used for items in and results out.
// Payload type is set per instance; depends on nothing else.
interface scc_stream_if #(
    parameter type T = logic
) (
    input logic i_clk
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/scc_time_pack.sv
// Packs the host time into the BCD layout of the output shift register.
// Depends on scc_pkg for the conversion helper and the item type.
module scc_time_pack (
    input  scc_pkg::t_in_item                    i_item,
    output logic [scc_pkg::TIME_BITS-1:0]        o_packed
);
    import scc_pkg::*;

    always_comb begin
        o_packed = {i_item.now_month,
                    1'b0, i_item.now_weekday,
                    bin_to_bcd({1'b0, i_item.now_day}),
                    bin_to_bcd({1'b0, i_item.now_hour}),
                    bin_to_bcd(i_item.now_minute),
                    bin_to_bcd(i_item.now_second)};
    end

endmodule

>>> hdl/scc_exec.sv
// Chip state (command latch, port levels, shift registers) and per-item result.
// Depends on scc_pkg and scc_time_pack.
module scc_exec #(
    parameter int SHIFT_BITS = 40
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  scc_pkg::t_in_item   i_item,
    output scc_pkg::t_out_item  o_result
);
    import scc_pkg::*;

    logic [2:0]            r_cmd;
    logic                  r_data_bit;
    logic                  r_strobe;
    logic                  r_clock;
    logic                  r_shift_en;
    logic [SHIFT_BITS-1:0] r_in_shift;
    logic [SHIFT_BITS-1:0] r_out_shift;

    logic [2:0]            n_cmd;
    logic                  n_data_bit;
    logic                  n_strobe;
    logic                  n_clock;
    logic                  n_shift_en;
    logic [SHIFT_BITS-1:0] n_in_shift;
    logic [SHIFT_BITS-1:0] n_out_shift;

    logic                  port_wr;
    logic                  stb;
    logic                  cck;
    logic                  strobe_fall;
    logic                  clock_fall;
    logic                  do_set;
    logic                  do_load;
    logic [TIME_BITS-1:0]  time_word;
    logic [SHIFT_BITS-1:0] out_base;

    scc_time_pack u_pack (
        .i_item   (i_item),
        .o_packed (time_word)
    );

    always_comb begin
        port_wr     = (i_item.func == FUNC_PORT);
        stb         = i_item.write_value[WV_STROBE_BIT];
        cck         = i_item.write_value[WV_CLOCK_BIT];
        strobe_fall = port_wr && r_strobe && !stb;
        do_set      = strobe_fall && (r_cmd == CMD_SET);
        do_load     = strobe_fall && (r_cmd == CMD_READ);

        n_cmd      = r_cmd;
        n_data_bit = r_data_bit;
        n_strobe   = r_strobe;
        n_clock    = r_clock;
        n_shift_en = r_shift_en;
        if (i_item.func == FUNC_CMD) begin
            n_cmd      = i_item.write_value[2:0];
            n_data_bit = i_item.write_value[WV_DATA_BIT];
        end
        if (port_wr) begin
            n_strobe = stb;
            n_clock  = cck;
        end
        // strobe first: the command decides whether this write's clock edge shifts
        if (strobe_fall) begin
            n_shift_en = (r_cmd == CMD_SHIFT);
        end

        clock_fall = port_wr && n_shift_en && r_clock && !cck;
        out_base   = do_load ? SHIFT_BITS'(time_word) : r_out_shift;
        if (clock_fall) begin
            n_in_shift  = {r_data_bit, r_in_shift[SHIFT_BITS-1:1]};
            n_out_shift = {1'b0, out_base[SHIFT_BITS-1:1]};
        end else begin
            n_in_shift  = r_in_shift;
            n_out_shift = out_base;
        end

        o_result = '0;
        if (i_item.func == FUNC_READ) begin
            o_result.read_byte = r_out_shift[0] ? READ_ONE : READ_ZERO;
        end
        // report the input register as it stood before this write's shift
        if (do_set) begin
            o_result.time_set    = 1'b1;
            o_result.set_month   = r_in_shift[39:36];
            o_result.set_weekday = r_in_shift[35:32];
            o_result.set_day     = bcd_to_bin(r_in_shift[31:24]);
            o_result.set_hour    = bcd_to_bin(r_in_shift[23:16]);
            o_result.set_minute  = bcd_to_bin(r_in_shift[15:8]);
            o_result.set_second  = bcd_to_bin(r_in_shift[7:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= CMD_HOLD;
            r_data_bit  <= 1'b0;
            r_strobe    <= 1'b0;
            r_clock     <= 1'b0;
            r_shift_en  <= 1'b0;
            r_in_shift  <= '0;
            r_out_shift <= '0;
        end else if (i_advance) begin
            r_cmd       <= n_cmd;
            r_data_bit  <= n_data_bit;
            r_strobe    <= n_strobe;
            r_clock     <= n_clock;
            r_shift_en  <= n_shift_en;
            r_in_shift  <= n_in_shift;
            r_out_shift <= n_out_shift;
        end
    end

    a_set_stops_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && o_result.time_set |=> !r_shift_en)
        else $error("shift enable still set after time set");

    a_cmd_write_keeps_regs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && (i_item.func == FUNC_CMD)
        |=> $stable(r_shift_en) && $stable(r_in_shift) && $stable(r_out_shift))
        else $error("command write changed shift state");

    a_read_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.read_byte != READ_ZERO) |-> (i_item.func == FUNC_READ))
        else $error("read byte set on a non-read item");

    a_no_shift_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_in_shift) && $stable(r_out_shift))
        else $error("shift registers moved without a transfer");

endmodule

>>> hdl/serial_calendar_clock_port.sv
// Serial calendar clock port: input register, state/execute logic, result register.
// A transferred item waits in the input register and moves to the result register
// once that slot is free. Throughput: one item per cycle unless the output stalls;
// the execute logic is a single registered pass.
// Synchronous active-low reset clears the chip state and both pipeline valids.
// Depends on scc_pkg, scc_stream_if and scc_exec.
module serial_calendar_clock_port #(
    parameter int SHIFT_BITS = 40
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    scc_stream_if.sink   i_in,
    scc_stream_if.source o_out
);
    import scc_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;

    logic       advance;
    t_out_item  result;

    // move the held item into the result register whenever that slot frees up
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    scc_exec #(
        .SHIFT_BITS (SHIFT_BITS)
    ) u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

endmodule

>>> dv/serial_calendar_clock_port_tb.sv
// Self-checking testbench for the serial calendar clock port: directed rows, then
// random command/strobe/clock/read sequences under several idle and stall phases.
// Depends on scc_pkg, scc_stream_if and the serial_calendar_clock_port RTL.
module serial_calendar_clock_port_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scc_pkg::*;

    localparam int SHIFT_W          = TIME_BITS;
    localparam int RANDOM_ACCESSES  = 750;
    localparam int PHASES           = 4;
    localparam int HOLD_CYCLES      = 200;
    localparam int SETTLE_CYCLES    = 8;

    localparam logic [1:0] FUNC_IDLE       = 2'd3;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    localparam logic [28:0] TM_ZERO = 29'd0;
    localparam logic [28:0] TM_MAX  = '1;
    localparam logic [28:0] TM_MID  = {4'd12, 3'd6, 5'd31, 5'd23, 6'd59, 6'd60};

    localparam t_out_item OUT_NONE      = '0;
    localparam t_out_item OUT_READ_HIGH = t_out_item'({READ_ONE, 41'd0});
    localparam t_out_item OUT_SET_BLANK = t_out_item'({READ_ZERO, 1'b1, 40'd0});

    typedef struct packed {
        logic [2:0]         cmd;
        logic               din;
        logic               strobe;
        logic               sclk;
        logic               shifting;
        logic [SHIFT_W-1:0] in_reg;
        logic [SHIFT_W-1:0] out_reg;
    } t_chip_state;

    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item want;
    } t_access_row;

    logic i_clk;
    logic i_rst_n;

    scc_stream_if #(.T(t_in_item))  in_if  (.i_clk(i_clk));
    scc_stream_if #(.T(t_out_item)) out_if (.i_clk(i_clk));

    serial_calendar_clock_port #(
        .SHIFT_BITS(SHIFT_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_chip_state  chip;
    t_out_item    port_results_due[$];
    t_access_row  directed_rows[$];
    int           accesses_sent;
    int           mismatch_count;
    int           src_idle_pct;
    int           snk_stall_pct;
    int           hold_request;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] packed_bcd(input int unsigned v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic logic [7:0] bcd_value(input logic [7:0] b);
        return 8'(int'(b[7:4]) * 10 + int'(b[3:0]));
    endfunction

    // Advance the chip copy by one port access and return the result it gives
    function automatic t_out_item predict_port_access(input t_in_item it);
        t_out_item r;
        logic      stb;
        logic      sclk_now;
        r = '0;
        case (it.func)
            FUNC_CMD: begin
                chip.cmd = it.write_value[2:0];
                chip.din = it.write_value[WV_DATA_BIT];
            end
            FUNC_PORT: begin
                stb      = it.write_value[WV_STROBE_BIT];
                sclk_now = it.write_value[WV_CLOCK_BIT];
                // strobe edge first, then the clock under the new shift enable
                if (chip.strobe && !stb) begin
                    case (chip.cmd)
                        CMD_SHIFT: chip.shifting = 1'b1;
                        CMD_SET: begin
                            chip.shifting = 1'b0;
                            r.time_set    = 1'b1;
                            r.set_month   = chip.in_reg[39:36];
                            r.set_weekday = chip.in_reg[35:32];
                            r.set_day     = bcd_value(chip.in_reg[31:24]);
                            r.set_hour    = bcd_value(chip.in_reg[23:16]);
                            r.set_minute  = bcd_value(chip.in_reg[15:8]);
                            r.set_second  = bcd_value(chip.in_reg[7:0]);
                        end
                        CMD_READ: begin
                            chip.shifting = 1'b0;
                            chip.out_reg  = {it.now_month, 1'b0, it.now_weekday,
                                             packed_bcd(it.now_day), packed_bcd(it.now_hour),
                                             packed_bcd(it.now_minute),
                                             packed_bcd(it.now_second)};
                        end
                        default: chip.shifting = 1'b0;
                    endcase
                end
                chip.strobe = stb;
                if (chip.shifting && chip.sclk && !sclk_now) begin
                    chip.in_reg  = {chip.din, chip.in_reg[SHIFT_W-1:1]};
                    chip.out_reg = chip.out_reg >> 1;
                end
                chip.sclk = sclk_now;
            end
            FUNC_READ: r.read_byte = chip.out_reg[0] ? READ_ONE : READ_ZERO;
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (port_results_due.size() == 0) begin
            report_mismatch("result arrived with nothing pending");
            return;
        end
        want = port_results_due.pop_front();
        if (got.read_byte !== want.read_byte)
            report_mismatch($sformatf("read_byte %0d, want %0d", got.read_byte, want.read_byte));
        if (got.time_set !== want.time_set)
            report_mismatch($sformatf("time_set %0d, want %0d", got.time_set, want.time_set));
        if (got.set_month !== want.set_month)
            report_mismatch($sformatf("set_month %0d, want %0d", got.set_month, want.set_month));
        if (got.set_weekday !== want.set_weekday)
            report_mismatch($sformatf("set_weekday %0d, want %0d",
                                      got.set_weekday, want.set_weekday));
        if (got.set_day !== want.set_day)
            report_mismatch($sformatf("set_day %0d, want %0d", got.set_day, want.set_day));
        if (got.set_hour !== want.set_hour)
            report_mismatch($sformatf("set_hour %0d, want %0d", got.set_hour, want.set_hour));
        if (got.set_minute !== want.set_minute)
            report_mismatch($sformatf("set_minute %0d, want %0d",
                                      got.set_minute, want.set_minute));
        if (got.set_second !== want.set_second)
            report_mismatch($sformatf("set_second %0d, want %0d",
                                      got.set_second, want.set_second));
    endtask

    // Result side: check each transfer, then pick ready for the next edge
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready)
                check_result(out_if.data);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99, 0) >= snk_stall_pct);
            end
        end
    end

    function automatic logic [7:0] cmd_wv(input logic [2:0] cmd, input logic din,
                                          input logic [3:0] fill);
        return {fill, din, cmd};
    endfunction

    function automatic logic [7:0] port_wv(input logic stb, input logic sclk,
                                           input logic [5:0] fill);
        return {fill[5:1], sclk, stb, fill[0]};
    endfunction

    function automatic t_in_item make_access(input logic [1:0] func, input logic [7:0] wv);
        t_in_item it;
        it.func        = func;
        it.write_value = wv;
        it.now_month   = 4'($urandom);
        it.now_weekday = 3'($urandom);
        it.now_day     = 5'($urandom);
        it.now_hour    = 5'($urandom);
        it.now_minute  = 6'($urandom);
        it.now_second  = 6'($urandom);
        return it;
    endfunction

    function automatic void add_row(input logic [1:0] func, input logic [7:0] wv,
                                    input logic [28:0] tm, input bit typed = 1'b0,
                                    input t_out_item want = '0);
        t_access_row row;
        row.it    = t_in_item'({func, wv, tm});
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // Offer one access, wait for its transfer, then log what it must produce
    task automatic drive_access(input t_in_item it, input bit typed = 1'b0,
                                input t_out_item want = '0);
        t_out_item pred;
        while ($urandom_range(99, 0) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        pred = predict_port_access(it);
        port_results_due.push_back(typed ? want : pred);
        accesses_sent++;
    endtask

    task automatic strobe_pulse();
        drive_access(make_access(FUNC_PORT, port_wv(1'b1, 1'b0, 6'($urandom))));
        drive_access(make_access(FUNC_PORT, port_wv(1'b0, 1'b0, 6'($urandom))));
    endtask

    task automatic clock_pulse();
        drive_access(make_access(FUNC_PORT, port_wv(1'b0, 1'b1, 6'($urandom))));
        drive_access(make_access(FUNC_PORT, port_wv(1'b0, 1'b0, 6'($urandom))));
    endtask

    // Shift a random word into the input register, then run a time set
    task automatic load_and_set();
        int nbits;
        nbits = ($urandom_range(3, 0) == 0) ? SHIFT_W + $urandom_range(4, 0)
                                            : $urandom_range(24, 1);
        drive_access(make_access(FUNC_CMD, cmd_wv(CMD_SHIFT, 1'($urandom), 4'($urandom))));
        if ($urandom_range(9, 0) != 0)
            strobe_pulse();
        repeat (nbits) begin
            drive_access(make_access(FUNC_CMD,
                                     cmd_wv(CMD_SHIFT, 1'($urandom), 4'($urandom))));
            clock_pulse();
            if ($urandom_range(7, 0) == 0)
                drive_access(make_access(FUNC_READ, 8'($urandom)));
        end
        drive_access(make_access(FUNC_CMD, cmd_wv(CMD_SET, 1'($urandom), 4'($urandom))));
        strobe_pulse();
    endtask

    // Load the host time, then shift it out bit by bit with reads
    task automatic read_out();
        int nbits;
        nbits = ($urandom_range(3, 0) == 0) ? SHIFT_W + $urandom_range(4, 0)
                                            : $urandom_range(16, 1);
        drive_access(make_access(FUNC_CMD, cmd_wv(CMD_READ, 1'($urandom), 4'($urandom))));
        strobe_pulse();
        drive_access(make_access(FUNC_READ, 8'($urandom)));
        drive_access(make_access(FUNC_CMD, cmd_wv(CMD_SHIFT, 1'($urandom), 4'($urandom))));
        strobe_pulse();
        repeat (nbits) begin
            clock_pulse();
            drive_access(make_access(FUNC_READ, 8'($urandom)));
        end
    endtask

    task automatic noise();
        repeat ($urandom_range(6, 1))
            drive_access(make_access(2'($urandom), 8'($urandom)));
    endtask

    // Drop valid and hold until every pending result is back
    task automatic settle();
        in_if.valid <= 1'b0;
        while (port_results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int src_pct[PHASES];
        int snk_pct[PHASES];
        int goal;
        src_pct = '{0, 81, 0, 37};
        snk_pct = '{0, 0, 81, 37};
        in_if.valid    = 1'b0;
        in_if.data     = '0;
        i_rst_n        = 1'b0;
        chip           = '0;
        accesses_sent  = 0;
        mismatch_count = 0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        hold_request   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(FUNC_READ, 8'h00, TM_ZERO, 1'b1, OUT_NONE);
        add_row(FUNC_IDLE, 8'hFF, TM_MAX, 1'b1, OUT_NONE);
        // time set straight after reset reports an all-zero word
        add_row(FUNC_CMD, cmd_wv(CMD_SET, 1'b0, 4'h0), TM_MID);
        add_row(FUNC_PORT, port_wv(1'b1, 1'b0, 6'h00), TM_MID);
        add_row(FUNC_PORT, port_wv(1'b0, 1'b0, 6'h00), TM_MID, 1'b1, OUT_SET_BLANK);
        // time read with every host field at its top value
        add_row(FUNC_CMD, cmd_wv(CMD_READ, 1'b1, 4'hF), TM_MID);
        add_row(FUNC_PORT, port_wv(1'b1, 1'b0, 6'h00), TM_MID);
        add_row(FUNC_PORT, port_wv(1'b0, 1'b0, 6'h00), TM_MAX);
        add_row(FUNC_READ, 8'hFF, TM_ZERO, 1'b1, OUT_READ_HIGH);
        // strobe and clock fall in one write
        add_row(FUNC_CMD, cmd_wv(CMD_SHIFT, 1'b1, 4'h0), TM_MID);
        add_row(FUNC_PORT, port_wv(1'b1, 1'b1, 6'h00), TM_MID);
        add_row(FUNC_PORT, port_wv(1'b0, 1'b0, 6'h00), TM_MID);
        add_row(FUNC_READ, 8'h00, TM_MID);
        add_row(FUNC_PORT, port_wv(1'b0, 1'b1, 6'h00), TM_MID);
        add_row(FUNC_PORT, port_wv(1'b0, 1'b0, 6'h3F), TM_MID);
        add_row(FUNC_READ, 8'h00, TM_MID);
        // hold, then a clock that must not shift
        add_row(FUNC_CMD, cmd_wv(CMD_HOLD, 1'b0, 4'h0), TM_MID);
        add_row(FUNC_PORT, port_wv(1'b1, 1'b0, 6'h00), TM_MID);
        add_row(FUNC_PORT, port_wv(1'b0, 1'b1, 6'h00), TM_MID);
        add_row(FUNC_PORT, port_wv(1'b0, 1'b0, 6'h00), TM_MID);
        // time set and a clock edge in one write
        add_row(FUNC_CMD, cmd_wv(CMD_SET, 1'b0, 4'hF), TM_MID);
        add_row(FUNC_PORT, port_wv(1'b1, 1'b1, 6'h00), TM_MID);
        add_row(FUNC_PORT, port_wv(1'b0, 1'b0, 6'h00), TM_MID);
        // spare command only stops shifting
        add_row(FUNC_CMD, cmd_wv(CMD_SPARE_LAST, 1'b1, 4'hF), TM_MID);
        add_row(FUNC_PORT, port_wv(1'b1, 1'b1, 6'h3F), TM_MID);
        add_row(FUNC_PORT, port_wv(1'b0, 1'b0, 6'h00), TM_MID);
        add_row(FUNC_READ, 8'h00, TM_MID);

        foreach (directed_rows[i])
            drive_access(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
        settle();

        goal = accesses_sent;
        for (int ph = 0; ph < PHASES; ph++) begin
            src_idle_pct  = src_pct[ph];
            snk_stall_pct = snk_pct[ph];
            // long receiver hold while the sender keeps offering
            if (ph == 0)
                hold_request = HOLD_CYCLES;
            goal += RANDOM_ACCESSES / PHASES;
            while (accesses_sent < goal) begin
                case ($urandom_range(9, 0)) inside
                    [0:3]: load_and_set();
                    [4:7]: read_out();
                    default: noise();
                endcase
            end
            settle();
        end

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
